>>> hw/rtl/pdec_pkg.sv
// Shared types, constants and helper functions for the pulse decoder.
package pdec_pkg;

    // Width of the captured pulse length and of every length register.
    localparam int DUR_W = 15;
    // Width of the tolerance register.
    localparam int TOL_W = 8;
    // Width of the configuration register index.
    localparam int CFG_IDX_W = 3;
    // Depth of the queue between the classifier and the decoder.
    localparam int QUEUE_DEPTH = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_LENGTH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAP_LENGTH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_LENGTH   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_LENGTH  = 3'd4;

    // Register values after reset.
    localparam logic [TOL_W-1:0] TOLERANCE_RESET    = 8'd10;
    localparam logic [DUR_W-1:0] START_LENGTH_RESET = 15'd85;
    localparam logic [DUR_W-1:0] GAP_LENGTH_RESET   = 15'd50;
    localparam logic [DUR_W-1:0] ONE_LENGTH_RESET   = 15'd70;
    localparam logic [DUR_W-1:0] ZERO_LENGTH_RESET  = 15'd28;

    // Classification of one pulse, passed from the front to the back.
    typedef struct packed {
        logic start_hit;
        logic gap_hit;
        logic one_hit;
        logic zero_hit;
        logic last;
    } pdec_class_t;

    // True when the pulse length lies strictly within tolerance of the reference.
    function automatic logic near_length(input logic [DUR_W-1:0] ref_len,
                                         input logic [DUR_W-1:0] dur,
                                         input logic [TOL_W-1:0] tol);
        logic [DUR_W-1:0] diff;
        diff = (ref_len > dur) ? (ref_len - dur) : (dur - ref_len);
        return diff < {{(DUR_W-TOL_W){1'b0}}, tol};
    endfunction

endpackage

>>> hw/rtl/pdec_front.sv
// Front end: configuration registers and per-pulse length classification.
module pdec_front
    import pdec_pkg::*;
#(
    parameter int DURATION_BITS = 15
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DUR_W-1:0]     cfg_data,
    input  logic                 pulse_level,
    input  logic [DUR_W-1:0]     pulse_duration,
    input  logic                 last_pulse,
    output pdec_class_t          pulse_class
);

    localparam int DUR_USED = (DURATION_BITS < DUR_W) ? DURATION_BITS : DUR_W;
    localparam logic [DUR_W-1:0] DUR_MASK = DUR_W'((17'(1) << DUR_USED) - 17'(1));

    logic [TOL_W-1:0] tolerance_reg;
    logic [DUR_W-1:0] start_length_reg;
    logic [DUR_W-1:0] gap_length_reg;
    logic [DUR_W-1:0] one_length_reg;
    logic [DUR_W-1:0] zero_length_reg;
    logic [DUR_W-1:0] dur;

    // Configuration writes; an index beyond the register list is dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tolerance_reg    <= TOLERANCE_RESET;
            start_length_reg <= START_LENGTH_RESET;
            gap_length_reg   <= GAP_LENGTH_RESET;
            one_length_reg   <= ONE_LENGTH_RESET;
            zero_length_reg  <= ZERO_LENGTH_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_TOLERANCE:    tolerance_reg    <= cfg_data[TOL_W-1:0];
                REG_START_LENGTH: start_length_reg <= cfg_data;
                REG_GAP_LENGTH:   gap_length_reg   <= cfg_data;
                REG_ONE_LENGTH:   one_length_reg   <= cfg_data;
                REG_ZERO_LENGTH:  zero_length_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Only the low capture bits of the duration take part in the compares.
    assign dur = pulse_duration & DUR_MASK;

    // Window compares against every reference length at once.
    always_comb begin
        pulse_class.start_hit = pulse_level &&
                                near_length(start_length_reg, dur, tolerance_reg);
        pulse_class.gap_hit   = !pulse_level &&
                                near_length(gap_length_reg, dur, tolerance_reg);
        pulse_class.one_hit   = pulse_level &&
                                near_length(one_length_reg, dur, tolerance_reg);
        pulse_class.zero_hit  = pulse_level &&
                                near_length(zero_length_reg, dur, tolerance_reg);
        pulse_class.last      = last_pulse;
    end

endmodule

>>> hw/rtl/pdec_queue.sv
// Small first-in first-out queue between the classifier and the decoder.
module pdec_queue #(
    parameter int WIDTH = 5,
    parameter int DEPTH = 2
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             wr_valid,
    output logic             wr_ready,
    input  logic [WIDTH-1:0] wr_data,
    output logic             rd_valid,
    input  logic             rd_ready,
    output logic [WIDTH-1:0] rd_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push;
    logic             pop;

    assign wr_ready = (count_reg != CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = slots_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    // Pointer and fill count update.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge aclk) begin
        if (push) begin
            slots_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

>>> hw/rtl/pdec_back.sv
// Back end: frame decoding state, byte assembly, checksum and result register.
module pdec_back
    import pdec_pkg::*;
#(
    parameter int FRAME_BYTES = 5
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cls_valid,
    output logic        cls_ready,
    input  pdec_class_t cls,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_humidity_whole,
    output logic [7:0]  m_humidity_fraction,
    output logic [7:0]  m_temperature_whole,
    output logic [7:0]  m_temperature_fraction,
    output logic [7:0]  m_received_checksum,
    output logic        m_start_found,
    output logic        m_overflow,
    output logic        m_checksum_ok
);

    localparam int IDX_W = $clog2(FRAME_BYTES + 1);
    localparam int OUT_BYTES = 4;

    logic             start_seen_reg, start_seen_next, start_upd;
    logic             gap_seen_reg, gap_seen_next, gap_upd;
    logic             overflow_reg, overflow_next, overflow_upd;
    logic [IDX_W-1:0] byte_index_reg, byte_index_next, byte_index_upd;
    logic [2:0]       bit_pos_reg, bit_pos_next, bit_pos_upd;
    logic [7:0]       bytes_reg [FRAME_BYTES];
    logic [7:0]       bytes_next [FRAME_BYTES];
    logic [7:0]       bytes_upd [FRAME_BYTES];
    logic [7:0]       sum;
    logic             pop;
    logic             out_free;

    logic             m_valid_reg, m_valid_next;
    logic [7:0]       out_bytes_reg [OUT_BYTES];
    logic [7:0]       out_bytes_upd [OUT_BYTES];
    logic [7:0]       checksum_reg;
    logic             start_found_reg;
    logic             overflow_out_reg;
    logic             checksum_ok_reg;

    // A pulse that produces no result never waits on the result register.
    assign out_free  = !m_valid_reg || m_ready;
    assign cls_ready = !cls.last || out_free;
    assign pop       = cls_valid && cls_ready;

    // Decoding step for the pulse at the head of the queue.
    always_comb begin
        start_upd      = start_seen_reg;
        gap_upd        = gap_seen_reg;
        overflow_upd   = overflow_reg;
        byte_index_upd = byte_index_reg;
        bit_pos_upd    = bit_pos_reg;
        for (int i = 0; i < FRAME_BYTES; i++) begin
            bytes_upd[i] = bytes_reg[i];
        end
        if (!overflow_reg) begin
            if (!start_seen_reg) begin
                start_upd = cls.start_hit;
            end else if (gap_seen_reg) begin
                if (byte_index_reg >= IDX_W'(FRAME_BYTES)) begin
                    overflow_upd = 1'b1;
                end else if (cls.one_hit || cls.zero_hit) begin
                    if (cls.one_hit) begin
                        for (int i = 0; i < FRAME_BYTES; i++) begin
                            if (byte_index_reg == IDX_W'(i)) begin
                                bytes_upd[i][bit_pos_reg] = 1'b1;
                            end
                        end
                    end
                    if (bit_pos_reg == 3'd0) begin
                        byte_index_upd = byte_index_reg + 1'b1;
                        bit_pos_upd    = 3'd7;
                    end else begin
                        bit_pos_upd = bit_pos_reg - 1'b1;
                    end
                    gap_upd = 1'b0;
                end
            end else begin
                gap_upd = cls.gap_hit;
            end
        end
    end

    // Checksum over every byte but the last one, modulo 256.
    always_comb begin
        sum = '0;
        for (int i = 0; i < FRAME_BYTES - 1; i++) begin
            sum = sum + bytes_upd[i];
        end
    end

    // Bytes that have no frame byte behind them read zero.
    for (genvar g = 0; g < OUT_BYTES; g++) begin : g_out
        if (g + 1 < FRAME_BYTES) begin : g_byte
            assign out_bytes_upd[g] = bytes_upd[g];
        end else begin : g_zero
            assign out_bytes_upd[g] = '0;
        end
    end

    // The last pulse of a frame returns the decoding state to its reset value.
    always_comb begin
        start_seen_next = start_seen_reg;
        gap_seen_next   = gap_seen_reg;
        overflow_next   = overflow_reg;
        byte_index_next = byte_index_reg;
        bit_pos_next    = bit_pos_reg;
        for (int i = 0; i < FRAME_BYTES; i++) begin
            bytes_next[i] = bytes_reg[i];
        end
        if (pop) begin
            if (cls.last) begin
                start_seen_next = 1'b0;
                gap_seen_next   = 1'b0;
                overflow_next   = 1'b0;
                byte_index_next = '0;
                bit_pos_next    = 3'd7;
                for (int i = 0; i < FRAME_BYTES; i++) begin
                    bytes_next[i] = '0;
                end
            end else begin
                start_seen_next = start_upd;
                gap_seen_next   = gap_upd;
                overflow_next   = overflow_upd;
                byte_index_next = byte_index_upd;
                bit_pos_next    = bit_pos_upd;
                for (int i = 0; i < FRAME_BYTES; i++) begin
                    bytes_next[i] = bytes_upd[i];
                end
            end
        end
    end

    // Result valid flag.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (pop && cls.last) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_seen_reg <= 1'b0;
            gap_seen_reg   <= 1'b0;
            overflow_reg   <= 1'b0;
            byte_index_reg <= '0;
            bit_pos_reg    <= 3'd7;
            m_valid_reg    <= 1'b0;
            for (int i = 0; i < FRAME_BYTES; i++) begin
                bytes_reg[i] <= '0;
            end
        end else begin
            start_seen_reg <= start_seen_next;
            gap_seen_reg   <= gap_seen_next;
            overflow_reg   <= overflow_next;
            byte_index_reg <= byte_index_next;
            bit_pos_reg    <= bit_pos_next;
            m_valid_reg    <= m_valid_next;
            for (int i = 0; i < FRAME_BYTES; i++) begin
                bytes_reg[i] <= bytes_next[i];
            end
        end
    end

    // Result payload is loaded when a last pulse leaves the queue.
    always_ff @(posedge aclk) begin
        if (pop && cls.last) begin
            for (int i = 0; i < OUT_BYTES; i++) begin
                out_bytes_reg[i] <= out_bytes_upd[i];
            end
            checksum_reg     <= bytes_upd[FRAME_BYTES-1];
            start_found_reg  <= start_upd;
            overflow_out_reg <= overflow_upd;
            checksum_ok_reg  <= (sum == bytes_upd[FRAME_BYTES-1]);
        end
    end

    assign m_valid                = m_valid_reg;
    assign m_humidity_whole       = out_bytes_reg[0];
    assign m_humidity_fraction    = out_bytes_reg[1];
    assign m_temperature_whole    = out_bytes_reg[2];
    assign m_temperature_fraction = out_bytes_reg[3];
    assign m_received_checksum    = checksum_reg;
    assign m_start_found          = start_found_reg;
    assign m_overflow             = overflow_out_reg;
    assign m_checksum_ok          = checksum_ok_reg;

endmodule

>>> hw/rtl/humidity_sensor_pulse_decoder_core.sv
// Top level of the single-wire humidity sensor pulse decoder.
//
// Input channel (s_*): one measured line pulse per transaction, with its
// level, its length in microsecond ticks and a flag marking the final pulse
// of a frame. Result channel (m_*): one transaction per frame, issued for the
// pulse marked last, carrying the five decoded bytes, the start and overflow
// flags and the checksum check.
// Configuration: cfg_we writes cfg_data into register cfg_index (tolerance,
// start, gap, one and zero lengths); write it only while no frame is in flight.
// Throughput is one pulse per cycle while s_ready is high. The front
// classifies a pulse in the cycle it is accepted; the decoder takes it
// from a two-entry queue, and the result appears on m_valid the cycle
// after the decoder takes the last pulse of the frame.
// When the receiver holds m_ready low, only a last pulse waits in the
// queue; once the queue fills, s_ready drops until the result is taken.
// A synchronous low aresetn restores the register defaults, clears the frame
// state and empties the queue and the result register.
module humidity_sensor_pulse_decoder_core
    import pdec_pkg::*;
#(
    parameter int FRAME_BYTES   = 5,
    parameter int DURATION_BITS = 15
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DUR_W-1:0]     cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_pulse_level,
    input  logic [DUR_W-1:0]     s_pulse_duration,
    input  logic                 s_last_pulse,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [7:0]           m_humidity_whole,
    output logic [7:0]           m_humidity_fraction,
    output logic [7:0]           m_temperature_whole,
    output logic [7:0]           m_temperature_fraction,
    output logic [7:0]           m_received_checksum,
    output logic                 m_start_found,
    output logic                 m_overflow,
    output logic                 m_checksum_ok
);

    pdec_class_t front_class;
    pdec_class_t back_class;
    logic        q_valid;
    logic        q_ready;

    // Classifier and configuration registers.
    pdec_front #(
        .DURATION_BITS(DURATION_BITS)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .pulse_level   (s_pulse_level),
        .pulse_duration(s_pulse_duration),
        .last_pulse    (s_last_pulse),
        .pulse_class   (front_class)
    );

    // Queue that lets the front and back stall independently.
    pdec_queue #(
        .WIDTH($bits(pdec_class_t)),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_valid(s_valid),
        .wr_ready(s_ready),
        .wr_data (front_class),
        .rd_valid(q_valid),
        .rd_ready(q_ready),
        .rd_data (back_class)
    );

    // Frame decoder and result register.
    pdec_back #(
        .FRAME_BYTES(FRAME_BYTES)
    ) u_back (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .cls_valid             (q_valid),
        .cls_ready             (q_ready),
        .cls                   (back_class),
        .m_valid               (m_valid),
        .m_ready               (m_ready),
        .m_humidity_whole      (m_humidity_whole),
        .m_humidity_fraction   (m_humidity_fraction),
        .m_temperature_whole   (m_temperature_whole),
        .m_temperature_fraction(m_temperature_fraction),
        .m_received_checksum   (m_received_checksum),
        .m_start_found         (m_start_found),
        .m_overflow            (m_overflow),
        .m_checksum_ok         (m_checksum_ok)
    );

endmodule

>>> dv/humidity_sensor_pulse_decoder_core_test.sv
// Self-checking testbench for the humidity sensor pulse decoder core.
module humidity_sensor_pulse_decoder_core_test;
    import pdec_pkg::*;

    localparam int NUM_BYTES       = 5;
    localparam int BITS_PER_FRAME  = 8 * NUM_BYTES;
    localparam int MAX_DUR         = (1 << DUR_W) - 1;
    localparam int TARGET_PULSES   = 650;
    localparam int TARGET_READINGS = 30;
    localparam int PHASE_PULSES    = 70;
    localparam int NUM_PHASES      = 6;
    localparam int PRESSURE_PHASE  = 1;
    localparam int NO_MATCH_PHASE  = 3;
    localparam int HOLD_CYCLES     = 300;
    localparam int DRAIN_CYCLES    = 8;
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int MAX_PRINTED     = 40;

    // Register indexes past the end of the list; writes to them are dropped.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = 3'd7;

    localparam logic LINE_LOW  = 1'b0;
    localparam logic LINE_HIGH = 1'b1;
    localparam logic FRAME_MID = 1'b0;
    localparam logic FRAME_END = 1'b1;

    typedef struct {
        logic             level;
        logic [DUR_W-1:0] duration;
        logic             last;
    } pulse_t;

    typedef struct {
        logic [7:0] humidity_whole;
        logic [7:0] humidity_fraction;
        logic [7:0] temperature_whole;
        logic [7:0] temperature_fraction;
        logic [7:0] received_checksum;
        logic       start_found;
        logic       overflow;
        logic       checksum_ok;
    } reading_t;

    typedef enum int { RX_STEADY, RX_HALF, RX_SPARSE, RX_MOSTLY } rx_pattern_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DUR_W-1:0]     cfg_data  = '0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    logic                 s_pulse_level    = 1'b0;
    logic [DUR_W-1:0]     s_pulse_duration = '0;
    logic                 s_last_pulse     = 1'b0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    logic [7:0]           m_humidity_whole;
    logic [7:0]           m_humidity_fraction;
    logic [7:0]           m_temperature_whole;
    logic [7:0]           m_temperature_fraction;
    logic [7:0]           m_received_checksum;
    logic                 m_start_found;
    logic                 m_overflow;
    logic                 m_checksum_ok;

    humidity_sensor_pulse_decoder_core DUT (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .cfg_we                (cfg_we),
        .cfg_index             (cfg_index),
        .cfg_data              (cfg_data),
        .s_valid               (s_valid),
        .s_ready               (s_ready),
        .s_pulse_level         (s_pulse_level),
        .s_pulse_duration      (s_pulse_duration),
        .s_last_pulse          (s_last_pulse),
        .m_valid               (m_valid),
        .m_ready               (m_ready),
        .m_humidity_whole      (m_humidity_whole),
        .m_humidity_fraction   (m_humidity_fraction),
        .m_temperature_whole   (m_temperature_whole),
        .m_temperature_fraction(m_temperature_fraction),
        .m_received_checksum   (m_received_checksum),
        .m_start_found         (m_start_found),
        .m_overflow            (m_overflow),
        .m_checksum_ok         (m_checksum_ok)
    );

    // Free-running clock with a period of 20 time units.
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Shadow copy of the configuration registers.
    logic [TOL_W-1:0] tol_cfg       = TOLERANCE_RESET;
    logic [DUR_W-1:0] start_len_cfg = START_LENGTH_RESET;
    logic [DUR_W-1:0] gap_len_cfg   = GAP_LENGTH_RESET;
    logic [DUR_W-1:0] one_len_cfg   = ONE_LENGTH_RESET;
    logic [DUR_W-1:0] zero_len_cfg  = ZERO_LENGTH_RESET;

    // Shadow copy of the frame decoding state.
    logic       frame_started = 1'b0;
    logic       gap_found     = 1'b0;
    int         byte_slot     = 0;
    int         bit_slot      = 7;
    logic [7:0] frame_data [NUM_BYTES] = '{default: 8'h00};
    logic       overflow_flag = 1'b0;

    pulse_t   pending_pulses[$];
    reading_t expected_readings[$];
    pulse_t   current_pulse;
    int       items_queued    = 0;
    int       readings_queued = 0;
    int       items_accepted  = 0;
    int       error_count     = 0;
    logic     stall_request   = 1'b0;

    // The pulse length counts as a match when it lies strictly inside the window.
    function automatic logic within_window(input logic [DUR_W-1:0] center,
                                           input logic [DUR_W-1:0] dur);
        int len_diff;
        len_diff = (center > dur) ? int'(center) - int'(dur) : int'(dur) - int'(center);
        return len_diff < int'(tol_cfg);
    endfunction

    // Advance the decoding state by one accepted pulse and queue the frame
    // reading when the pulse closes the frame.
    task automatic decode_pulse(input pulse_t p);
        logic       is_one;
        logic       is_zero;
        logic [7:0] sum;
        reading_t   r;
        if (!overflow_flag) begin
            if (!frame_started) begin
                frame_started = p.level && within_window(start_len_cfg, p.duration);
            end else if (gap_found) begin
                if (byte_slot >= NUM_BYTES) begin
                    overflow_flag = 1'b1;
                end else begin
                    is_one  = p.level && within_window(one_len_cfg, p.duration);
                    is_zero = p.level && within_window(zero_len_cfg, p.duration);
                    if (is_one || is_zero) begin
                        if (is_one)
                            frame_data[byte_slot][bit_slot] = 1'b1;
                        if (bit_slot == 0) begin
                            byte_slot++;
                            bit_slot = 7;
                        end else begin
                            bit_slot--;
                        end
                        gap_found = 1'b0;
                    end
                end
            end else begin
                gap_found = !p.level && within_window(gap_len_cfg, p.duration);
            end
        end
        if (p.last) begin
            sum = 8'h00;
            for (int i = 0; i < NUM_BYTES - 1; i++)
                sum = sum + frame_data[i];
            r.humidity_whole       = frame_data[0];
            r.humidity_fraction    = frame_data[1];
            r.temperature_whole    = frame_data[2];
            r.temperature_fraction = frame_data[3];
            r.received_checksum    = frame_data[NUM_BYTES-1];
            r.start_found          = frame_started;
            r.overflow             = overflow_flag;
            r.checksum_ok          = (sum == frame_data[NUM_BYTES-1]);
            expected_readings.push_back(r);
            frame_started = 1'b0;
            gap_found     = 1'b0;
            byte_slot     = 0;
            bit_slot      = 7;
            overflow_flag = 1'b0;
            for (int i = 0; i < NUM_BYTES; i++)
                frame_data[i] = 8'h00;
        end
    endtask

    task automatic report_error(input string msg);
        error_count++;
        if (error_count <= MAX_PRINTED)
            $display("ERROR at %0t: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
            report_error($sformatf("%s expected 0x%0h, got 0x%0h", name, want, got));
    endtask

    // Compare one result transaction with the oldest expected reading.
    task automatic check_reading();
        reading_t want;
        if (expected_readings.size() == 0) begin
            report_error("result transaction with no frame pending");
            return;
        end
        want = expected_readings.pop_front();
        check_field("humidity_whole", want.humidity_whole, m_humidity_whole);
        check_field("humidity_fraction", want.humidity_fraction, m_humidity_fraction);
        check_field("temperature_whole", want.temperature_whole, m_temperature_whole);
        check_field("temperature_fraction", want.temperature_fraction,
                    m_temperature_fraction);
        check_field("received_checksum", want.received_checksum, m_received_checksum);
        check_field("start_found", want.start_found, m_start_found);
        check_field("overflow", want.overflow, m_overflow);
        check_field("checksum_ok", want.checksum_ok, m_checksum_ok);
    endtask

    // Input driver: offers queued pulses in bursts separated by random gaps.
    int   burst_left = 1;
    int   gap_left   = 0;
    logic offer_next;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            burst_left = $urandom_range(1, 40);
            gap_left   = 0;
        end else begin
            offer_next = s_valid;
            if (s_valid && s_ready) begin
                decode_pulse(current_pulse);
                items_accepted++;
                offer_next = 1'b0;
            end
            if (!offer_next) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_pulses.size() != 0) begin
                    current_pulse = pending_pulses.pop_front();
                    s_pulse_level    <= current_pulse.level;
                    s_pulse_duration <= current_pulse.duration;
                    s_last_pulse     <= current_pulse.last;
                    offer_next = 1'b1;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
            s_valid <= offer_next;
        end
    end

    // Result monitor: checks each accepted transaction and drives m_ready
    // from a random pattern picked anew whenever pat_cnt wraps, plus one long hold-off.
    int          hold_left = 0;
    logic        hold_done = 1'b0;
    int          pat_cnt   = 0;
    rx_pattern_t pat_mode  = RX_STEADY;
    logic        ready_next;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready)
                check_reading();
            if (stall_request && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                ready_next = 1'b0;
            end else begin
                if (pat_cnt == 0)
                    pat_mode = rx_pattern_t'($urandom_range(0, 3));
                pat_cnt = (pat_cnt + 1) % 32;
                case (pat_mode)
                    RX_STEADY: ready_next = 1'b1;
                    RX_HALF:   ready_next = 1'($urandom_range(0, 1));
                    RX_SPARSE: ready_next = ($urandom_range(0, 3) == 0);
                    default:   ready_next = ($urandom_range(0, 6) != 0);
                endcase
            end
            m_ready <= ready_next;
        end
    end

    // Watchdog on cycles in which neither channel moves a transaction.
    int stall_cycles = 0;

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL humidity_sensor_pulse_decoder_core");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic add_pulse(input logic level, input logic [DUR_W-1:0] dur,
                             input logic last);
        pulse_t p;
        p.level    = level;
        p.duration = dur;
        p.last     = last;
        pending_pulses.push_back(p);
        items_queued++;
        if (last)
            readings_queued++;
    endtask

    // A length near the center, mostly inside the window, now and then exactly on its edge.
    function automatic logic [DUR_W-1:0] jitter(input logic [DUR_W-1:0] center);
        int off;
        int val;
        if (tol_cfg == 0)
            return center;
        if ($urandom_range(0, 11) == 0)
            off = int'(tol_cfg);
        else
            off = $urandom_range(0, int'(tol_cfg) - 1);
        val = ($urandom_range(0, 1) == 1) ? int'(center) + off : int'(center) - off;
        if (val < 0)
            val = 0;
        if (val > MAX_DUR)
            val = MAX_DUR;
        return DUR_W'(val);
    endfunction

    // A stray pulse: either any length at all or close to one of the references.
    task automatic add_noise_pulse(input logic last);
        logic [DUR_W-1:0] dur;
        case ($urandom_range(0, 4))
            0:       dur = jitter(start_len_cfg);
            1:       dur = jitter(gap_len_cfg);
            2:       dur = jitter(one_len_cfg);
            3:       dur = jitter(zero_len_cfg);
            default: dur = DUR_W'($urandom_range(0, MAX_DUR));
        endcase
        add_pulse(1'($urandom_range(0, 1)), dur, last);
    endtask

    // A frame as the sensor sends it: start pulse, then gap and bit pairs,
    // with stray pulses mixed in at the given percentage.
    task automatic add_frame(input int nbits, input logic [BITS_PER_FRAME-1:0] payload,
                             input int noise_pct);
        logic bit_val;
        add_pulse(LINE_HIGH, jitter(start_len_cfg), FRAME_MID);
        for (int i = 0; i < nbits; i++) begin
            if ($urandom_range(0, 99) < noise_pct)
                add_noise_pulse(FRAME_MID);
            add_pulse(LINE_LOW, jitter(gap_len_cfg), FRAME_MID);
            if ($urandom_range(0, 99) < noise_pct)
                add_noise_pulse(FRAME_MID);
            if (i < BITS_PER_FRAME)
                bit_val = payload[BITS_PER_FRAME-1-i];
            else
                bit_val = 1'($urandom_range(0, 1));
            add_pulse(LINE_HIGH, jitter(bit_val ? one_len_cfg : zero_len_cfg), FRAME_MID);
        end
        // The trailing pulse carries the end-of-frame mark.
        if ($urandom_range(0, 3) == 0)
            add_noise_pulse(FRAME_END);
        else
            add_pulse(LINE_LOW, DUR_W'($urandom_range(0, 80)), FRAME_END);
    endtask

    task automatic add_random_frame();
        int                        pick;
        logic [7:0]                b [NUM_BYTES];
        logic [BITS_PER_FRAME-1:0] payload;
        int                        n;
        for (int i = 0; i < NUM_BYTES - 1; i++)
            b[i] = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 3) == 0)
            b[NUM_BYTES-1] = 8'($urandom_range(0, 255));
        else
            b[NUM_BYTES-1] = b[0] + b[1] + b[2] + b[3];
        payload = {b[0], b[1], b[2], b[3], b[4]};
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
            add_frame(BITS_PER_FRAME, payload, 0);
        end else if (pick < 27) begin
            add_frame(BITS_PER_FRAME, payload, 8);
        end else if (pick < 47) begin
            add_frame($urandom_range(0, BITS_PER_FRAME - 1), payload, 4);
        end else if (pick < 55) begin
            add_frame(BITS_PER_FRAME + $urandom_range(1, 4), payload, 0);
        end else begin
            n = $urandom_range(1, 8);
            repeat (n - 1) add_noise_pulse(FRAME_MID);
            add_noise_pulse(FRAME_END);
        end
    endtask

    // Short directed sequence at the reset configuration: window edges,
    // skipped data pulses, extreme lengths and frames without a start.
    task automatic add_directed();
        add_pulse(LINE_LOW, '0, FRAME_END);
        add_pulse(LINE_HIGH, DUR_W'(MAX_DUR), FRAME_END);
        add_pulse(LINE_HIGH, start_len_cfg + DUR_W'(tol_cfg), FRAME_MID);
        add_pulse(LINE_HIGH, start_len_cfg + DUR_W'(tol_cfg) - 1'b1, FRAME_MID);
        add_pulse(LINE_HIGH, gap_len_cfg, FRAME_MID);
        add_pulse(LINE_LOW, gap_len_cfg + DUR_W'(tol_cfg) - 1'b1, FRAME_MID);
        add_pulse(LINE_HIGH, one_len_cfg + DUR_W'(tol_cfg), FRAME_MID);
        add_pulse(LINE_LOW, DUR_W'(MAX_DUR), FRAME_MID);
        add_pulse(LINE_HIGH, one_len_cfg + DUR_W'(tol_cfg) - 1'b1, FRAME_MID);
        add_pulse(LINE_LOW, gap_len_cfg - DUR_W'(tol_cfg) + 1'b1, FRAME_MID);
        add_pulse(LINE_HIGH, zero_len_cfg - DUR_W'(tol_cfg) + 1'b1, FRAME_MID);
        add_pulse(LINE_LOW, gap_len_cfg, FRAME_MID);
        add_pulse(LINE_HIGH, one_len_cfg, FRAME_END);
        add_pulse(LINE_LOW, '0, FRAME_MID);
        add_pulse(LINE_HIGH, start_len_cfg - DUR_W'(tol_cfg) + 1'b1, FRAME_MID);
        add_pulse(LINE_LOW, gap_len_cfg, FRAME_MID);
        add_pulse(LINE_HIGH, zero_len_cfg, FRAME_END);
        add_pulse(LINE_HIGH, start_len_cfg, FRAME_MID);
        add_pulse(LINE_LOW, gap_len_cfg, FRAME_MID);
        add_pulse(LINE_LOW, '0, FRAME_END);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DUR_W-1:0] data);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            REG_TOLERANCE:    tol_cfg       = data[TOL_W-1:0];
            REG_START_LENGTH: start_len_cfg = data;
            REG_GAP_LENGTH:   gap_len_cfg   = data;
            REG_ONE_LENGTH:   one_len_cfg   = data;
            REG_ZERO_LENGTH:  zero_len_cfg  = data;
            default: ;
        endcase
    endtask

    // Wait until every pulse is taken and every reading has come back, then
    // let the pipeline drain pulses that produce no result.
    task automatic wait_idle();
        while (items_accepted != items_queued || expected_readings.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic apply_setting(input int phase);
        case (phase)
            PRESSURE_PHASE: begin
                // Upper data bits above the tolerance width must be ignored.
                write_reg(REG_TOLERANCE, {7'h7F, 8'($urandom_range(2, 60))});
                write_reg(REG_START_LENGTH, DUR_W'($urandom_range(0, MAX_DUR)));
                write_reg(REG_GAP_LENGTH, DUR_W'($urandom_range(0, MAX_DUR)));
                write_reg(REG_ONE_LENGTH, DUR_W'($urandom_range(0, MAX_DUR)));
                write_reg(REG_ZERO_LENGTH, DUR_W'($urandom_range(0, MAX_DUR)));
            end
            2: begin
                write_reg(REG_TOLERANCE, DUR_W'(255));
                write_reg(REG_START_LENGTH, DUR_W'(MAX_DUR));
                write_reg(REG_GAP_LENGTH, '0);
                write_reg(REG_ONE_LENGTH, DUR_W'(MAX_DUR));
                write_reg(REG_ZERO_LENGTH, '0);
            end
            NO_MATCH_PHASE: begin
                // A zero tolerance window matches nothing.
                write_reg(REG_TOLERANCE, '0);
                write_reg(REG_START_LENGTH, '0);
                write_reg(REG_GAP_LENGTH, DUR_W'(MAX_DUR));
            end
            4: begin
                // One and zero windows coincide; a one takes precedence.
                write_reg(REG_TOLERANCE, DUR_W'(1));
                write_reg(REG_START_LENGTH, DUR_W'(1));
                write_reg(REG_ONE_LENGTH, DUR_W'(500));
                write_reg(REG_ZERO_LENGTH, DUR_W'(500));
            end
            default: begin
                write_reg(REG_SPARE_FIRST, DUR_W'(MAX_DUR));
                write_reg(REG_SPARE_LAST, '0);
                write_reg(REG_TOLERANCE, DUR_W'(TOLERANCE_RESET));
                write_reg(REG_START_LENGTH, START_LENGTH_RESET);
                write_reg(REG_GAP_LENGTH, GAP_LENGTH_RESET);
                write_reg(REG_ONE_LENGTH, ONE_LENGTH_RESET);
                write_reg(REG_ZERO_LENGTH, ZERO_LENGTH_RESET);
            end
        endcase
    endtask

    // Stimulus sequence: reset, directed pulses, then phases of random frames
    // under different register settings.
    initial begin
        int phase_goal;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        add_directed();
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            if (phase > 0) begin
                wait_idle();
                apply_setting(phase);
                @(negedge aclk);
            end
            if (phase == PRESSURE_PHASE) begin
                // Frames closing on every pulse pile up while the receiver holds off.
                stall_request = 1'b1;
                repeat (16) add_noise_pulse(FRAME_END);
            end
            phase_goal = items_queued + ((phase == NO_MATCH_PHASE) ? 40 : PHASE_PULSES);
            while (items_queued < phase_goal)
                add_random_frame();
        end
        while (items_queued < TARGET_PULSES || readings_queued < TARGET_READINGS)
            add_random_frame();
        wait_idle();
        if (error_count == 0)
            $display("PASS humidity_sensor_pulse_decoder_core");
        else
            $display("FAIL humidity_sensor_pulse_decoder_core");
        $finish;
    end

endmodule
